[hw/rtl/tlpra_pkg.sv]
package tlpra_pkg;

	localparam int DIR_ENTRIES_DEF   = 16;
	localparam int TABLE_ENTRIES_DEF = 1024;

	localparam int REQ_TYPE_W = 2;
	localparam int PAGE_CNT_W = 15;
	localparam int VPAGE_W    = 14;
	localparam int FRAME_W    = 20;
	// widest page address: 1024 directories of 1024 entries
	localparam int MEM_AW_MAX = 20;

	localparam logic [REQ_TYPE_W-1:0] REQ_FIND  = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_MAP   = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_UNMAP = 2'd2;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [PAGE_CNT_W-1:0] page_count;
		logic [VPAGE_W-1:0]    virt_page;
		logic [FRAME_W-1:0]    phys_frame;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [VPAGE_W-1:0] start_page;
		logic               need_invalidate;
		logic               table_created;
	} rsp_t;

	typedef struct packed {
		logic                  en;
		logic [MEM_AW_MAX-1:0] addr;
		logic                  present;
		logic                  frame_en;
		logic [FRAME_W-1:0]    frame;
	} mem_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CLEAR,
		ST_WRITE,
		ST_FIND,
		ST_RESP
	} state_t;

endpackage

[hw/rtl/two_level_page_run_allocator_top.sv]
// channel | signals                    | transaction
// req     | req_valid, req_ready, req  | one find, map or unmap request
// rsp     | rsp_valid, rsp_ready, rsp  | one result per request
//
// Find: reads one present bit a cycle, one per entry of each present directory and one per
// absent directory scanned, up to the run's end.
// Map/unmap: check, write and respond; out of range or unmapping in an absent directory skips
// the write; a map that creates a table first clears its TABLE_ENTRIES entries.
// Reset clears directory bits and control; page memory needs no clearing pass.
// A waiting result does not block acceptance; only a second finished result waits.
module two_level_page_run_allocator_top #(
	parameter int DIR_ENTRIES   = tlpra_pkg::DIR_ENTRIES_DEF,
	parameter int TABLE_ENTRIES = tlpra_pkg::TABLE_ENTRIES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  tlpra_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output tlpra_pkg::rsp_t rsp
);
	localparam int AW = $clog2(DIR_ENTRIES * TABLE_ENTRIES);

	tlpra_pkg::rsp_t    res, rsp_q;
	tlpra_pkg::mem_wr_t wr;
	logic               rsp_valid_q, rsp_free, done, idle, rd_present;
	logic [AW-1:0]      rd_addr;

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = idle;

	tlpra_ctrl #(
		.DIR_ENTRIES  (DIR_ENTRIES),
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req_valid && idle),
		.req       (req),
		.idle      (idle),
		.rsp_free  (rsp_free),
		.done      (done),
		.res       (res),
		.rd_addr   (rd_addr),
		.rd_present(rd_present),
		.wr        (wr)
	);

	tlpra_page_mem #(
		.DEPTH(DIR_ENTRIES * TABLE_ENTRIES)
	) u_mem (
		.clk       (clk),
		.rd_addr   (rd_addr),
		.rd_present(rd_present),
		.wr        (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hw/rtl/tlpra_page_mem.sv]
module tlpra_page_mem #(
	parameter int DEPTH = tlpra_pkg::DIR_ENTRIES_DEF * tlpra_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic                   rd_present,
	input  tlpra_pkg::mem_wr_t     wr
);
	localparam int AW = $clog2(DEPTH);

	logic                          pres_mem  [DEPTH];
	logic [tlpra_pkg::FRAME_W-1:0] frame_mem [DEPTH];
	logic                          rd_present_q;

	always_ff @(posedge clk) begin
		rd_present_q <= pres_mem[rd_addr];
		if (wr.en) begin
			pres_mem[wr.addr[AW-1:0]] <= wr.present;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.frame_en) begin
			frame_mem[wr.addr[AW-1:0]] <= wr.frame;
		end
	end

	assign rd_present = rd_present_q;

endmodule

[hw/rtl/tlpra_ctrl.sv]
module tlpra_ctrl #(
	parameter int DIR_ENTRIES   = tlpra_pkg::DIR_ENTRIES_DEF,
	parameter int TABLE_ENTRIES = tlpra_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  tlpra_pkg::req_t       req,
	output logic                  idle,
	input  logic                  rsp_free,
	output logic                  done,
	output tlpra_pkg::rsp_t       res,
	output logic [$clog2(DIR_ENTRIES*TABLE_ENTRIES)-1:0] rd_addr,
	input  logic                  rd_present,
	output tlpra_pkg::mem_wr_t    wr
);
	localparam int PAGES  = DIR_ENTRIES * TABLE_ENTRIES;
	localparam int AW     = $clog2(PAGES);
	localparam int DW     = $clog2(DIR_ENTRIES);
	localparam int CW     = $clog2(TABLE_ENTRIES);
	localparam int RW     = AW + 1;
	localparam int RCP_SH = 24;
	localparam int RCP_W  = 25;
	localparam int PW     = tlpra_pkg::VPAGE_W + RCP_W;
	// ceil(2^24 / TABLE_ENTRIES): exact quotient for any 14-bit page number
	localparam logic [RCP_W-1:0] RCP = RCP_W'((2**RCP_SH + TABLE_ENTRIES - 1) / TABLE_ENTRIES);
	localparam logic [DW-1:0] LAST_DIR = DW'(DIR_ENTRIES - 1);
	localparam logic [CW-1:0] LAST_ENT = CW'(TABLE_ENTRIES - 1);

	tlpra_pkg::state_t state_q, state_d;
	tlpra_pkg::req_t   req_q;
	tlpra_pkg::rsp_t   res_q;
	logic [PW-1:0]             prod_q;
	logic [DIR_ENTRIES-1:0]    dir_q;
	logic [AW-1:0]             base_q;
	logic [CW-1:0]             cnt_q;
	logic                      created_q;
	logic [DW-1:0]             sd_q;
	logic [CW-1:0]             se_q;
	logic [AW-1:0]             sp_q;
	logic                      tok_v_s1, tok_abs_s1;
	logic [AW-1:0]             tok_p_s1;
	logic [RW-1:0]             run_q, run_n;
	logic [AW-1:0]             start_q, start_n;
	logic [tlpra_pkg::PAGE_CNT_W-1:0] want_q;

	logic [PW-RCP_SH-1:0] dir_num;
	logic [DW-1:0]        d_idx;
	logic                 in_range, dir_hit, is_map;
	logic [AW-1:0]        vp_addr;
	logic                 free, hit, issue_en, scan_end;

	assign dir_num  = prod_q[PW-1:RCP_SH];
	assign d_idx    = dir_num[DW-1:0];
	assign in_range = 32'(dir_num) < 32'(DIR_ENTRIES);
	assign dir_hit  = dir_q[d_idx];
	assign is_map   = req_q.req_type == tlpra_pkg::REQ_MAP;
	assign vp_addr  = AW'(req_q.virt_page);

	// scan result stage: token from last cycle meets its memory read
	always_comb begin
		free    = tok_abs_s1 || !rd_present;
		start_n = (run_q == '0 && free) ? tok_p_s1 : start_q;
		if (!free) begin
			run_n = '0;
		end else if (tok_abs_s1) begin
			run_n = run_q + RW'(TABLE_ENTRIES);
		end else begin
			run_n = run_q + RW'(1);
		end
	end

	assign hit      = (state_q == tlpra_pkg::ST_FIND) && tok_v_s1 && free
		&& (32'(run_n) >= 32'(want_q));
	assign issue_en = (state_q == tlpra_pkg::ST_FIND) && (sd_q != LAST_DIR) && !hit;
	assign scan_end = (sd_q == LAST_DIR) && !tok_v_s1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlpra_pkg::ST_IDLE: begin
				if (start) begin
					unique case (req.req_type)
						tlpra_pkg::REQ_FIND:  state_d = tlpra_pkg::ST_FIND;
						tlpra_pkg::REQ_MAP,
						tlpra_pkg::REQ_UNMAP: state_d = tlpra_pkg::ST_CHECK;
						default:              state_d = tlpra_pkg::ST_RESP;
					endcase
				end
			end
			tlpra_pkg::ST_CHECK: begin
				if (!in_range) begin
					state_d = tlpra_pkg::ST_RESP;
				end else if (dir_hit) begin
					state_d = tlpra_pkg::ST_WRITE;
				end else if (is_map) begin
					state_d = tlpra_pkg::ST_CLEAR;
				end else begin
					state_d = tlpra_pkg::ST_RESP;
				end
			end
			tlpra_pkg::ST_CLEAR: begin
				if (cnt_q == LAST_ENT) begin
					state_d = tlpra_pkg::ST_WRITE;
				end
			end
			tlpra_pkg::ST_WRITE: state_d = tlpra_pkg::ST_RESP;
			tlpra_pkg::ST_FIND: begin
				if (hit || scan_end) begin
					state_d = tlpra_pkg::ST_RESP;
				end
			end
			tlpra_pkg::ST_RESP: begin
				if (rsp_free) begin
					state_d = tlpra_pkg::ST_IDLE;
				end
			end
			default: state_d = tlpra_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		idle    = state_q == tlpra_pkg::ST_IDLE;
		done    = (state_q == tlpra_pkg::ST_RESP) && rsp_free;
		rd_addr = (state_q == tlpra_pkg::ST_FIND) ? sp_q : vp_addr;
		wr      = '0;
		unique case (state_q)
			tlpra_pkg::ST_CLEAR: begin
				wr.en   = 1'b1;
				wr.addr = tlpra_pkg::MEM_AW_MAX'(base_q + AW'(cnt_q));
			end
			tlpra_pkg::ST_WRITE: begin
				wr.en       = 1'b1;
				wr.addr     = tlpra_pkg::MEM_AW_MAX'(vp_addr);
				wr.present  = is_map;
				wr.frame_en = is_map;
				wr.frame    = req_q.phys_frame;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tlpra_pkg::ST_IDLE;
			dir_q    <= '0;
			tok_v_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			tok_v_s1 <= issue_en;
			if (state_q == tlpra_pkg::ST_CHECK && in_range && is_map && !dir_hit) begin
				dir_q[d_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == tlpra_pkg::ST_IDLE) begin
			req_q     <= req;
			prod_q    <= req.virt_page * RCP;
			want_q    <= (req.page_count == '0) ? tlpra_pkg::PAGE_CNT_W'(1) : req.page_count;
			run_q     <= '0;
			start_q   <= '0;
			sd_q      <= '0;
			se_q      <= '0;
			sp_q      <= '0;
			cnt_q     <= '0;
			created_q <= 1'b0;
			res_q     <= '0;
		end
		unique case (state_q)
			tlpra_pkg::ST_CHECK: begin
				base_q    <= AW'(d_idx * TABLE_ENTRIES);
				created_q <= in_range && is_map && !dir_hit;
			end
			tlpra_pkg::ST_CLEAR: cnt_q <= cnt_q + CW'(1);
			tlpra_pkg::ST_WRITE: begin
				res_q.need_invalidate <= !created_q && rd_present;
				res_q.table_created   <= created_q;
			end
			tlpra_pkg::ST_FIND: begin
				if (tok_v_s1) begin
					run_q   <= run_n;
					start_q <= start_n;
				end
				if (hit) begin
					res_q.found      <= 1'b1;
					res_q.start_page <= tlpra_pkg::VPAGE_W'(start_n);
				end
				if (issue_en) begin
					if (dir_q[sd_q]) begin
						sp_q <= sp_q + AW'(1);
						if (se_q == LAST_ENT) begin
							se_q <= '0;
							sd_q <= sd_q + DW'(1);
						end else begin
							se_q <= se_q + CW'(1);
						end
					end else begin
						sp_q <= sp_q + AW'(TABLE_ENTRIES);
						sd_q <= sd_q + DW'(1);
					end
				end
			end
			default: ;
		endcase
		tok_abs_s1 <= !dir_q[sd_q];
		tok_p_s1   <= sp_q;
	end

	assign res = res_q;

endmodule

[hw/rtl/tlpra_checker.sv]
module tlpra_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input tlpra_pkg::req_t req,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input tlpra_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result dropped or changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready again right after a transaction");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.start_page == '0)
		else $error("start page set without a hit");

	a_create_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.table_created |-> !rsp.need_invalidate && !rsp.found)
		else $error("new table reported an invalidate or a hit");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> !rsp.need_invalidate)
		else $error("find result carries an invalidate");

endmodule

bind two_level_page_run_allocator_top tlpra_checker u_tlpra_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
